// ===== rtl/gaz_pkg.sv =====
// Shared types, constants and the arctangent table for the grid azimuth block.
// No dependencies; every other file in rtl/ uses this package.
`timescale 1ns / 1ps

package gaz_pkg;

  // Field formats
  localparam int unsigned COORD_BITS       = 32;
  localparam int unsigned ANGLE_FRAC_BITS  = 16;
  localparam int unsigned CORDIC_STEPS_DEF = 24;
  localparam int unsigned ROM_LEN          = 32;

  // Exact coordinate difference and CORDIC datapath widths
  localparam int unsigned DW         = COORD_BITS + 1;
  localparam int unsigned INIT_SHIFT = 59 - COORD_BITS;
  localparam int unsigned XW         = 62;
  localparam int unsigned ZW         = 52;

  // Radians to degrees: z * 180/pi with a Q32 scale, split product
  localparam int unsigned              SCALE_W   = 38;
  localparam logic [SCALE_W-1:0]       DEG_SCALE = 38'd246083499208;
  localparam int unsigned              ZSPLIT    = 25;
  localparam int unsigned              ZHW       = ZW - 1 - ZSPLIT;
  localparam int unsigned              PHW       = ZHW + SCALE_W;
  localparam int unsigned              RND_POS   = 56 - ANGLE_FRAC_BITS;
  localparam int unsigned              DEG_SHIFT = 57 - ANGLE_FRAC_BITS;

  // Angle widths and fixed angles in Q9.F degrees
  localparam int unsigned     AW     = 9 + ANGLE_FRAC_BITS;
  localparam int unsigned     BW     = AW + 1;
  localparam logic [AW-1:0]   DEG90A = AW'(90) << ANGLE_FRAC_BITS;
  localparam logic [BW-1:0]   DEG90  = BW'(90) << ANGLE_FRAC_BITS;
  localparam logic [BW-1:0]   DEG180 = BW'(180) << ANGLE_FRAC_BITS;
  localparam logic [BW-1:0]   DEG270 = BW'(270) << ANGLE_FRAC_BITS;
  localparam logic [BW-1:0]   DEG360 = BW'(360) << ANGLE_FRAC_BITS;

  // Input beat: two points
  typedef struct packed {
    logic signed [COORD_BITS-1:0] from_x;
    logic signed [COORD_BITS-1:0] from_y;
    logic signed [COORD_BITS-1:0] to_x;
    logic signed [COORD_BITS-1:0] to_y;
  } gaz_in_t;

  // Output beat: bearing and coincidence flag
  typedef struct packed {
    logic [AW-1:0] bearing;
    logic          points_coincide;
  } gaz_out_t;

  // Direction class carried alongside the CORDIC vector
  typedef struct packed {
    logic dx_neg;
    logic dy_neg;
    logic dx_zero;
    logic dy_zero;
  } gaz_cls_t;

  // CORDIC stage payload
  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    gaz_cls_t             cls;
  } gaz_vec_t;

  // Elaboration only: floor(2^62 / den) by shift and subtract
  function automatic logic [63:0] pow62_quot(input logic [127:0] den);
    logic [127:0] rem;
    logic [63:0]  q;
    rem = '0;
    q   = '0;
    for (int b = 62; b >= 0; b--) begin
      rem = rem << 1;
      if (b == 62) rem[0] = 1'b1;
      if (rem >= den) begin
        rem  = rem - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Elaboration only: atan(1/n) in Q62 from the alternating series
  function automatic logic [63:0] atan_inv_q62(input logic [127:0] n);
    logic [127:0] nn;
    logic [127:0] pw;
    logic [63:0]  acc;
    logic [63:0]  term;
    logic         done;
    nn   = n * n;
    pw   = n;
    acc  = '0;
    done = 1'b0;
    for (int k = 0; k < 32; k++) begin
      if (!done) begin
        if (pw > (128'd1 << 62)) begin
          done = 1'b1;
        end else begin
          term = pow62_quot(pw * 128'(2 * k + 1));
          if ((k % 2) == 0) acc = acc + term;
          else              acc = acc - term;
          pw = pw * nn;
        end
      end
    end
    return acc;
  endfunction

  // Elaboration only: table entry atan(2^-idx) in Q50 radians
  function automatic logic [ZW-1:0] atan_q50(input int unsigned idx);
    logic [63:0] v;
    if (idx == 0) v = atan_inv_q62(128'd2) + atan_inv_q62(128'd3);
    else          v = atan_inv_q62(128'd1 << idx);
    return ZW'((v + 64'd2048) >> 12);
  endfunction

endpackage

// ===== rtl/gaz_prep.sv =====
// Front end of the grid azimuth pipeline: point differences, then magnitude,
// direction class and CORDIC start vector. Depends on gaz_pkg.
`timescale 1ns / 1ps

module gaz_prep (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  gaz_pkg::gaz_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output gaz_pkg::gaz_vec_t out_vec_o
);

  localparam int unsigned CB = gaz_pkg::COORD_BITS;
  localparam int unsigned DW = gaz_pkg::DW;
  localparam int unsigned XW = gaz_pkg::XW;

  logic                 s1_valid_q, s2_valid_q;
  logic                 s1_ready, s2_ready;
  logic signed [DW-1:0] dx_d, dy_d, dx_q, dy_q;
  logic        [DW-1:0] ax, ay;
  gaz_pkg::gaz_vec_t    vec_d, vec_q;

  assign s2_ready   = !s2_valid_q || out_ready_i;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;

  // Form exact differences, one bit wider than the coordinates
  assign dx_d = $signed({in_data_i.to_x[CB-1], in_data_i.to_x})
              - $signed({in_data_i.from_x[CB-1], in_data_i.from_x});
  assign dy_d = $signed({in_data_i.to_y[CB-1], in_data_i.to_y})
              - $signed({in_data_i.from_y[CB-1], in_data_i.from_y});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      dx_q <= dx_d;
      dy_q <= dy_d;
    end
  end

  // Take magnitudes, classify the direction, scale into the CORDIC range
  always_comb begin
    ax = dx_q[DW-1] ? DW'(-dx_q) : DW'(dx_q);
    ay = dy_q[DW-1] ? DW'(-dy_q) : DW'(dy_q);
    vec_d.x           = $signed(XW'(ax) << gaz_pkg::INIT_SHIFT);
    vec_d.y           = $signed(XW'(ay) << gaz_pkg::INIT_SHIFT);
    vec_d.z           = '0;
    vec_d.cls.dx_neg  = dx_q[DW-1];
    vec_d.cls.dy_neg  = dy_q[DW-1];
    vec_d.cls.dx_zero = (dx_q == '0);
    vec_d.cls.dy_zero = (dy_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      vec_q <= vec_d;
    end
  end

  assign out_valid_o = s2_valid_q;
  assign out_vec_o   = vec_q;

endmodule

// ===== rtl/gaz_cordic_stage.sv =====
// One registered CORDIC vectoring iteration with a fixed shift and angle.
// Depends on gaz_pkg for the vector type and the arctangent table.
`timescale 1ns / 1ps

module gaz_cordic_stage #(
  parameter int unsigned STEP = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  gaz_pkg::gaz_vec_t in_vec_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output gaz_pkg::gaz_vec_t out_vec_o
);

  localparam int unsigned ZW = gaz_pkg::ZW;
  localparam int unsigned XW = gaz_pkg::XW;
  localparam logic signed [ZW-1:0] ATAN = $signed(gaz_pkg::atan_q50(STEP));

  logic                 valid_q;
  logic                 ready;
  logic signed [XW-1:0] xs, ys;
  gaz_pkg::gaz_vec_t    vec_d, vec_q;

  assign ready      = !valid_q || out_ready_i;
  assign in_ready_o = ready;

  // Rotate toward the x axis; both updates use the incoming x and y
  always_comb begin
    xs    = in_vec_i.x >>> STEP;
    ys    = in_vec_i.y >>> STEP;
    vec_d = in_vec_i;
    if (!in_vec_i.y[XW-1]) begin
      vec_d.x = in_vec_i.x + ys;
      vec_d.y = in_vec_i.y - xs;
      vec_d.z = in_vec_i.z + ATAN;
    end else begin
      vec_d.x = in_vec_i.x - ys;
      vec_d.y = in_vec_i.y + xs;
      vec_d.z = in_vec_i.z - ATAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready && in_valid_i) begin
      vec_q <= vec_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_vec_o   = vec_q;

endmodule

// ===== rtl/gaz_deg.sv =====
// Back end of the grid azimuth pipeline: radians to degrees (multiply, round,
// clamp) and quadrant placement into the output register. Depends on gaz_pkg.
`timescale 1ns / 1ps

module gaz_deg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  gaz_pkg::gaz_vec_t in_vec_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output gaz_pkg::gaz_out_t out_data_o
);

  localparam int unsigned ZW      = gaz_pkg::ZW;
  localparam int unsigned ZSPLIT  = gaz_pkg::ZSPLIT;
  localparam int unsigned ZHW     = gaz_pkg::ZHW;
  localparam int unsigned PHW     = gaz_pkg::PHW;
  localparam int unsigned SCALE_W = gaz_pkg::SCALE_W;
  localparam int unsigned LOW     = ZSPLIT + SCALE_W;
  localparam int unsigned AW      = gaz_pkg::AW;
  localparam int unsigned BW      = gaz_pkg::BW;
  localparam logic [PHW:0] RND    = (PHW + 1)'(1) << gaz_pkg::RND_POS;

  logic s1_valid_q, s2_valid_q, s3_valid_q;
  logic s1_ready, s2_ready, s3_ready;

  // Stage 1: split product of z and the degree scale
  logic [ZW-2:0]      zu;
  logic [ZHW-1:0]     zh;
  logic [ZSPLIT-1:0]  zl;
  logic [LOW-1:0]     lo_full;
  logic [PHW-1:0]     p_hi_d, p_hi_q;
  logic [SCALE_W-1:0] p_lo_d, p_lo_q;
  logic               zpos_d, zpos_q;
  gaz_pkg::gaz_cls_t  cls1_q;

  // Stage 2: round and clamp
  logic [PHW:0]       sum;
  logic [AW-1:0]      a_raw, a_d, a_q;
  gaz_pkg::gaz_cls_t  cls2_q;

  // Stage 3: placement
  logic [BW-1:0]      a_ext, b;
  gaz_pkg::gaz_out_t  out_d, out_q;

  assign s3_ready   = !s3_valid_q || out_ready_i;
  assign s2_ready   = !s2_valid_q || s3_ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;

  // Multiply both halves of z by the scale
  always_comb begin
    zu      = in_vec_i.z[ZW-2:0];
    zh      = zu[ZW-2:ZSPLIT];
    zl      = zu[ZSPLIT-1:0];
    zpos_d  = !in_vec_i.z[ZW-1] && (in_vec_i.z != '0);
    p_hi_d  = PHW'(zh) * PHW'(gaz_pkg::DEG_SCALE);
    lo_full = LOW'(zl) * LOW'(gaz_pkg::DEG_SCALE);
    p_lo_d  = lo_full[LOW-1:ZSPLIT];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      p_hi_q <= p_hi_d;
      p_lo_q <= p_lo_d;
      zpos_q <= zpos_d;
      cls1_q <= in_vec_i.cls;
    end
  end

  // Round half up to the output scale, clamp to a right angle
  always_comb begin
    sum   = (PHW + 1)'(p_hi_q) + (PHW + 1)'(p_lo_q) + RND;
    a_raw = AW'(sum >> gaz_pkg::DEG_SHIFT);
    if (!zpos_q) begin
      a_d = '0;
    end else if (a_raw > gaz_pkg::DEG90A) begin
      a_d = gaz_pkg::DEG90A;
    end else begin
      a_d = a_raw;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      a_q    <= a_d;
      cls2_q <= cls1_q;
    end
  end

  // Place the angle by quadrant; axes and coincident points are exact
  always_comb begin
    a_ext                 = BW'(a_q);
    out_d.points_coincide = 1'b0;
    if (cls2_q.dx_zero && cls2_q.dy_zero) begin
      b                     = '0;
      out_d.points_coincide = 1'b1;
    end else if (cls2_q.dx_zero) begin
      b = cls2_q.dy_neg ? gaz_pkg::DEG270 : gaz_pkg::DEG90;
    end else if (cls2_q.dy_zero) begin
      b = cls2_q.dx_neg ? gaz_pkg::DEG180 : '0;
    end else if (!cls2_q.dx_neg && !cls2_q.dy_neg) begin
      b = a_ext;
    end else if (cls2_q.dx_neg && !cls2_q.dy_neg) begin
      b = gaz_pkg::DEG180 - a_ext;
    end else if (cls2_q.dx_neg) begin
      b = gaz_pkg::DEG180 + a_ext;
    end else begin
      b = gaz_pkg::DEG360 - a_ext;
    end
    // wrap a full circle back to zero
    if (b >= gaz_pkg::DEG360) b = '0;
    out_d.bearing = AW'(b);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (s3_ready) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_ready && s2_valid_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = s3_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/grid_azimuth_from_points_top.sv =====
// Grid azimuth top level: direction from one point to another in degrees.
// Depends on gaz_pkg, gaz_prep, gaz_cordic_stage and gaz_deg.
//
// Input channel (in_valid_i / in_ready_o / in_data_i) takes one beat per pair
// of points; output channel (out_valid_o / out_ready_i / out_data_o) returns
// one beat per input beat, in order, with the bearing in unsigned Q9.16
// degrees over [0,360) counted counter-clockwise from +x, and a flag for
// coincident points (bearing then zero).
// The pipeline has two front-end stages, one register per CORDIC iteration,
// then multiply, round/clamp and the output register. Throughput is one beat
// per cycle while the receiver keeps out_ready_i high; each stage holds one
// item and the CORDIC iterations are unrolled.
// Reset clears every stage's valid bit; the pipeline then accepts at once.
// When the receiver stalls, beats pile up behind the output register, one per
// stage; in_ready_o drops only once every stage is full, and nothing is lost.
`timescale 1ns / 1ps

module grid_azimuth_from_points_top #(
  parameter int unsigned CORDIC_STEPS = gaz_pkg::CORDIC_STEPS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  gaz_pkg::gaz_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output gaz_pkg::gaz_out_t out_data_o
);

  logic              vld [0:CORDIC_STEPS];
  logic              rdy [0:CORDIC_STEPS];
  gaz_pkg::gaz_vec_t vec [0:CORDIC_STEPS];

  // Differences and start vector
  gaz_prep u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(vld[0]),
    .out_ready_i(rdy[0]),
    .out_vec_o  (vec[0])
  );

  // Unrolled CORDIC iterations, one register each
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    gaz_cordic_stage #(
      .STEP(i)
    ) u_step (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .in_valid_i (vld[i]),
      .in_ready_o (rdy[i]),
      .in_vec_i   (vec[i]),
      .out_valid_o(vld[i+1]),
      .out_ready_i(rdy[i+1]),
      .out_vec_o  (vec[i+1])
    );
  end

  // Degrees, rounding and quadrant placement
  gaz_deg u_deg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (vld[CORDIC_STEPS]),
    .in_ready_o (rdy[CORDIC_STEPS]),
    .in_vec_i   (vec[CORDIC_STEPS]),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

`ifndef SYNTH
  // A coincident-point beat always carries a zero bearing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.points_coincide |-> out_data_o.bearing == '0)
    else $error("coincident points with nonzero bearing");

  // Bearing stays below a full circle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.bearing < gaz_pkg::AW'(gaz_pkg::DEG360))
    else $error("bearing out of range");

  // The pipeline backs up only behind a waiting output beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty output register");

  // With the output drained last cycle, the input is not stalled now unless an output beat waits again
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |=> in_ready_o || out_valid_o)
    else $error("input stalled after output register went empty");
`endif

endmodule

// ===== tb/tb.sv =====
// Self-checking bench for grid_azimuth_from_points_top: drives point pairs, predicts
// each bearing with a bit-exact CORDIC model of its own and scoreboards every beat.
// Depends on gaz_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb;

  typedef longint unsigned u64_t;
  typedef logic signed [gaz_pkg::COORD_BITS-1:0] coord_t;

  localparam int unsigned FRAC        = gaz_pkg::ANGLE_FRAC_BITS;
  localparam int unsigned PRE_SHIFT   = 59 - gaz_pkg::COORD_BITS;
  localparam int unsigned STEPS       = gaz_pkg::CORDIC_STEPS_DEF;
  localparam int unsigned PIPE_CYCLES = STEPS + 5;
  localparam int unsigned HOLD_CYCLES = 150;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned PHASES      = 7;
  localparam int unsigned PHASE_ITEMS = 200;
  localparam u64_t        RAD2DEG_Q32 = 64'd246083499208;
  localparam u64_t        ONE_DEG     = 64'd1 << FRAC;
  localparam coord_t      C_MIN       = 32'sh8000_0000;
  localparam coord_t      C_MAX       = 32'sh7FFF_FFFF;

  // Bearing predictor and queue of bearings still owed by the block
  class bearing_scoreboard;
    u64_t              atan_q50[gaz_pkg::ROM_LEN];
    gaz_pkg::gaz_out_t owed_bearings[$];
    int                errors;
    int                pairs_seen;
    int                n_coincide;
    int                n_axis;
    int                n_wrap;

    function new();
      for (int i = 0; i < gaz_pkg::ROM_LEN; i++) begin
        u64_t v;
        if (i == 0) v = inv_atan_q62(2) + inv_atan_q62(3);
        else        v = inv_atan_q62(u64_t'(1) << i);
        atan_q50[i] = (v + 64'd2048) >> 12;
      end
    endfunction

    // atan(1/n) in Q62 radians from the alternating series
    function u64_t inv_atan_q62(u64_t n);
      u64_t nn, pw, acc, k, term;
      nn  = n * n;
      pw  = (64'd1 << 62) / n;
      acc = 0;
      k   = 0;
      while (pw != 0) begin
        term = pw / (2 * k + 1);
        if (k[0] == 1'b0) acc = acc + term;
        else              acc = acc - term;
        pw = pw / nn;
        k++;
      end
      return acc;
    endfunction

    // First-quadrant angle in Q.FRAC degrees for ax > 0, ay > 0
    function u64_t first_quadrant_deg(u64_t ax, u64_t ay);
      longint x, y, z, xs, ys;
      u64_t   zh, zl, t, a;
      x = longint'(ax << PRE_SHIFT);
      y = longint'(ay << PRE_SHIFT);
      z = 0;
      for (int i = 0; i < STEPS && i < gaz_pkg::ROM_LEN; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          z = z + longint'(atan_q50[i]);
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - longint'(atan_q50[i]);
        end
      end
      if (z <= 0) return 0;
      zh = u64_t'(z) >> 25;
      zl = u64_t'(z) & 64'h1FF_FFFF;
      t  = zh * RAD2DEG_Q32 + ((zl * RAD2DEG_Q32) >> 25);
      a  = (t + (64'd1 << (56 - FRAC))) >> (57 - FRAC);
      if (a > 90 * ONE_DEG) a = 90 * ONE_DEG;
      return a;
    endfunction

    // Direction from the first point to the second, placed by quadrant
    function gaz_pkg::gaz_out_t bearing_of(gaz_pkg::gaz_in_t p);
      longint            dx, dy;
      u64_t              ax, ay, a, b;
      gaz_pkg::gaz_out_t r;
      dx = longint'($signed(p.to_x)) - longint'($signed(p.from_x));
      dy = longint'($signed(p.to_y)) - longint'($signed(p.from_y));
      ax = (dx < 0) ? u64_t'(-dx) : u64_t'(dx);
      ay = (dy < 0) ? u64_t'(-dy) : u64_t'(dy);
      r.points_coincide = 1'b0;
      b = 0;
      if (dx == 0 && dy == 0) begin
        r.points_coincide = 1'b1;
        n_coincide++;
      end else if (dx == 0) begin
        b = (dy > 0) ? 90 * ONE_DEG : 270 * ONE_DEG;
        n_axis++;
      end else if (dy == 0) begin
        b = (dx > 0) ? 0 : 180 * ONE_DEG;
        n_axis++;
      end else begin
        a = first_quadrant_deg(ax, ay);
        if (dx > 0 && dy > 0) b = a;
        else if (dx < 0 && dy > 0) b = 180 * ONE_DEG - a;
        else if (dx < 0) b = 180 * ONE_DEG + a;
        else b = 360 * ONE_DEG - a;
        if (b >= 360 * ONE_DEG) begin
          b = 0;
          n_wrap++;
        end
      end
      r.bearing = b[gaz_pkg::AW-1:0];
      return r;
    endfunction

    function void note_input(gaz_pkg::gaz_in_t p);
      pairs_seen++;
      owed_bearings.push_back(bearing_of(p));
    endfunction

    function int outstanding();
      return owed_bearings.size();
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
    endtask

    // Compare one output beat with the oldest owed bearing
    task check_result(gaz_pkg::gaz_out_t got);
      gaz_pkg::gaz_out_t want;
      if (owed_bearings.size() == 0) begin
        report_mismatch($sformatf("unexpected beat bearing=%h flag=%b",
                                  got.bearing, got.points_coincide));
      end else begin
        want = owed_bearings.pop_front();
        if (got.bearing !== want.bearing)
          report_mismatch($sformatf("bearing got %h want %h", got.bearing, want.bearing));
        if (got.points_coincide !== want.points_coincide)
          report_mismatch($sformatf("points_coincide got %b want %b",
                                    got.points_coincide, want.points_coincide));
      end
    endtask
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  gaz_pkg::gaz_in_t  in_data_i;
  logic              out_valid_o;
  logic              out_ready_i;
  gaz_pkg::gaz_out_t out_data_o;

  bearing_scoreboard board;
  bit tx_idle;
  bit rx_idle;
  int hold_requests;
  int holds_done;
  int quiet_cycles;

  grid_azimuth_from_points_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Record accepted input beats and check accepted output beats
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) board.note_input(in_data_i);
      if (out_valid_o && out_ready_i) board.check_result(out_data_o);
    end
  end

  // End the run when no beat moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no beat moved for %0d cycles", quiet_cycles);
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: random ready gaps, plus a long hold on request
  initial begin
    int gap;
    out_ready_i <= 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (holds_done < hold_requests) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        holds_done++;
      end
      gap = rx_idle ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o && holds_done >= hold_requests) @(posedge clk_i);
    end
  end

  // Offer one pair after an optional gap; return at the accepting edge
  task automatic send_pair(input gaz_pkg::gaz_in_t p);
    int gap;
    gap = tx_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= p;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Stop offering and wait until every owed bearing has come back
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.outstanding() != 0) @(posedge clk_i);
  endtask

  function automatic gaz_pkg::gaz_in_t pair(coord_t fx, coord_t fy, coord_t tx, coord_t ty);
    gaz_pkg::gaz_in_t p;
    p.from_x = fx;
    p.from_y = fy;
    p.to_x   = tx;
    p.to_y   = ty;
    return p;
  endfunction

  function automatic coord_t edge_coord();
    case ($urandom_range(0, 4))
      0:       return C_MIN;
      1:       return C_MAX;
      2:       return 0;
      3:       return -1;
      default: return 1;
    endcase
  endfunction

  function automatic coord_t scaled_offset();
    coord_t d;
    d = $urandom;
    return d >>> $urandom_range(0, 31);
  endfunction

  // Mix full-range pairs with axis, coincident, edge and short-range pairs
  function automatic gaz_pkg::gaz_in_t random_pair();
    gaz_pkg::gaz_in_t p;
    p.from_x = $urandom;
    p.from_y = $urandom;
    case ($urandom_range(0, 9)) inside
      [0:2]: begin
        p.to_x = $urandom;
        p.to_y = $urandom;
      end
      3: begin
        p.to_x = p.from_x;
        p.to_y = p.from_y;
      end
      4: begin
        p.to_x = p.from_x;
        p.to_y = p.from_y + scaled_offset();
      end
      5: begin
        p.to_x = p.from_x + scaled_offset();
        p.to_y = p.from_y;
      end
      6: p = pair(edge_coord(), edge_coord(), edge_coord(), edge_coord());
      7: begin
        p.to_x = p.from_x + coord_t'($urandom_range(0, 16)) - 8;
        p.to_y = p.from_y + coord_t'($urandom_range(0, 16)) - 8;
      end
      default: begin
        p.to_x = p.from_x + scaled_offset();
        p.to_y = p.from_y + scaled_offset();
      end
    endcase
    return p;
  endfunction

  initial begin
    gaz_pkg::gaz_in_t directed_pairs[$];
    board         = new();
    tx_idle       = 1'b1;
    rx_idle       = 1'b1;
    hold_requests = 0;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: coincident points, the four axes, full-span diagonals,
    // tiny angles in each half plane (including the wrap to zero) and near-vertical
    directed_pairs = '{
      pair(0, 0, 0, 0), pair(C_MAX, C_MIN, C_MAX, C_MIN), pair(-1, -1, -1, -1),
      pair(0, 0, 5, 0), pair(0, 0, -5, 0), pair(3, 0, 3, 7), pair(3, 0, 3, -7),
      pair(C_MIN, 0, C_MAX, 0), pair(C_MAX, 0, C_MIN, 0),
      pair(0, C_MIN, 0, C_MAX), pair(0, C_MAX, 0, C_MIN),
      pair(C_MIN, C_MIN, C_MAX, C_MAX), pair(C_MAX, C_MAX, C_MIN, C_MIN),
      pair(C_MAX, C_MIN, C_MIN, C_MAX), pair(C_MIN, C_MAX, C_MAX, C_MIN),
      pair(0, 0, 1, 1), pair(0, 0, -1, 1), pair(0, 0, -1, -1), pair(0, 0, 1, -1),
      pair(C_MIN, 0, C_MAX, 1), pair(C_MIN, 1, C_MAX, 0),
      pair(C_MAX, 0, C_MIN, 1), pair(C_MAX, 1, C_MIN, 0),
      pair(0, C_MIN, 1, C_MAX), pair(0, C_MAX, -1, C_MIN), pair(1, 2, 4, 6)
    };
    foreach (directed_pairs[i]) send_pair(directed_pairs[i]);
    wait_for_drain();

    // Random phases; two of them open with a long receiver hold against a
    // back-to-back sender, and each ends with the sender paused until drained
    for (int ph = 0; ph < PHASES; ph++) begin
      bit long_hold;
      long_hold = (ph == 2 || ph == 5);
      if (long_hold) hold_requests++;
      tx_idle = (ph % 2 == 1) && !long_hold;
      rx_idle = (ph % 3 != 0);
      for (int n = 0; n < PHASE_ITEMS; n++) send_pair(random_pair());
      wait_for_drain();
    end

    repeat (PIPE_CYCLES + 10) @(posedge clk_i);
    $display("Checked %0d point pairs: %0d coincident, %0d on an axis, %0d wrapped to zero.",
             board.pairs_seen, board.n_coincide, board.n_axis, board.n_wrap);
    $display("Receiver held off %0d times for %0d cycles; %0d mismatches.",
             holds_done, HOLD_CYCLES, board.errors);
    if (board.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
